// ===== rtl/lbtc_pkg.sv =====
// Package for the line buffer tab compressor: item and result types,
// queue command type, back-end state encoding and character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbtc_pkg;

	// Default line store depth and command queue depth
	localparam int LBTC_LINE_MAX = 56;
	localparam int LBTC_QDEPTH   = 4;

	// Character codes
	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_SP  = 8'd32;

	// Operation codes of an input item
	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic       suppress;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       last;
		logic [5:0] column;
	} result_t;

	// Work handed from the front end to the back end
	typedef enum logic [1:0] {
		CMD_STATUS,
		CMD_WRITE,
		CMD_RELEASE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
		logic [5:0] column;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WRITE,
		BK_FETCH,
		BK_EXAM,
		BK_PEND,
		BK_TRIG,
		BK_STATUS
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/line_buffer_tab_compressor.sv =====
// With an idle back end, a status result passes the command queue, the back-end state
// and result registers; a stored character also passes the store write state. The back
// end pops, writes and reports an ordinary character, and a tab's spaces likewise;
// a release fetches and examines each stored character through the single store read
// port, emits each output character and ends with the trigger result.
// The front end takes one item per cycle until the 4-entry command queue fills.
// Reset clears the fill position, queue and control state; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module line_buffer_tab_compressor import lbtc_pkg::*; #(
	parameter int LINE_MAX = LBTC_LINE_MAX
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire logic    item_valid,
	output logic         item_stall,
	output result_t      result,
	output logic         result_valid,
	input  wire logic    result_stall
);

	localparam int PW = $clog2(LINE_MAX + 1);
	localparam int QW = $bits(cmd_t) + 2 * PW;

	cmd_t          f_cmd;
	logic [PW-1:0] f_start;
	logic [PW-1:0] f_stop;
	logic          f_push;
	logic          q_full;
	logic [QW-1:0] q_dout;
	logic          q_valid;
	logic          q_pop;
	cmd_t          b_cmd;
	logic [PW-1:0] b_start;
	logic [PW-1:0] b_stop;

	lbtc_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (f_push),
		.cmd        (f_cmd),
		.cmd_start  (f_start),
		.cmd_stop   (f_stop)
	);

	lbtc_cmd_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    ({f_cmd, f_start, f_stop}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	assign {b_cmd, b_start, b_stop} = q_dout;

	lbtc_back #(.LINE_MAX(LINE_MAX)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (b_cmd),
		.cmd_start    (b_start),
		.cmd_stop     (b_stop),
		.cmd_valid    (q_valid),
		.cmd_pop      (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire

// ===== rtl/lbtc_front.sv =====
// Front end: accepts items, tracks the fill position and turns each item
// into one command for the back end. Depends on lbtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbtc_front import lbtc_pkg::*; #(
	parameter int LINE_MAX = LBTC_LINE_MAX,
	localparam int PW = $clog2(LINE_MAX + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire item_t         item,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire logic          q_full,
	output logic               push,
	output cmd_t               cmd,
	output logic [PW-1:0]      cmd_start,
	output logic [PW-1:0]      cmd_stop
);

	logic [PW-1:0] fill_q;
	logic [PW-1:0] fill_nx;
	logic [PW:0]   tab_up;
	logic [PW-1:0] tab_end;
	logic          line_full;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;
	assign line_full  = (fill_q >= PW'(LINE_MAX));

	// Next tab stop, clipped at the end of the store
	assign tab_up  = ({1'b0, fill_q} | (PW+1)'(7)) + (PW+1)'(1);
	assign tab_end = (tab_up > (PW+1)'(LINE_MAX)) ? PW'(LINE_MAX) : tab_up[PW-1:0];

	// Classify the item
	always_comb begin
		cmd.kind   = CMD_STATUS;
		cmd.ch     = item.char_code;
		cmd.column = 6'(fill_q);
		cmd_start  = fill_q;
		cmd_stop   = fill_q;
		fill_nx    = fill_q;
		if (item.suppress) begin
			cmd.kind = CMD_STATUS;
		end else if (item.op == OP_FLUSH) begin
			if (fill_q != '0) begin
				cmd.kind  = CMD_RELEASE;
				cmd.ch    = CH_NL;
				cmd_start = '0;
				fill_nx   = '0;
			end
		end else if (item.char_code == CH_NL || line_full) begin
			// a release walks the whole stored line from the start
			cmd.kind  = CMD_RELEASE;
			cmd_start = '0;
			fill_nx   = '0;
		end else if (item.char_code == CH_TAB) begin
			cmd.kind   = CMD_WRITE;
			cmd.ch     = CH_SP;
			cmd_stop   = tab_end;
			cmd.column = 6'(tab_end);
			fill_nx    = tab_end;
		end else if (item.char_code != CH_NUL) begin
			cmd.kind   = CMD_WRITE;
			cmd_stop   = fill_q + PW'(1);
			cmd.column = 6'(fill_q + PW'(1));
			fill_nx    = fill_q + PW'(1);
		end
	end

	// Fill position tracks every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			fill_q <= fill_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbtc_cmd_queue.sv =====
// Small FIFO of commands between the front and back ends.
// Depends on lbtc_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none

module lbtc_cmd_queue import lbtc_pkg::*; #(
	parameter int W = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [W-1:0]  din,
	output logic               full,
	input  wire logic          pop,
	output logic [W-1:0]       dout,
	output logic               valid
);

	localparam int QAW = $clog2(LBTC_QDEPTH);

	logic [W-1:0]   entry_q [LBTC_QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = (count_q == (QAW+1)'(LBTC_QDEPTH));
	assign valid = (count_q != '0);
	assign dout  = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop && valid) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push && !full, pop && valid})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbtc_back.sv =====
// Back end: owns the line store, executes write, status and release
// commands, compresses space runs into tabs and drives the result register.
// Depends on lbtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbtc_back import lbtc_pkg::*; #(
	parameter int LINE_MAX = LBTC_LINE_MAX,
	localparam int PW = $clog2(LINE_MAX + 1),
	localparam int AW = $clog2(LINE_MAX),
	localparam int TW = $clog2(LINE_MAX / 8 + 2)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire logic [PW-1:0] cmd_start,
	input  wire logic [PW-1:0] cmd_stop,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	output result_t            result,
	output logic               result_valid,
	input  wire logic          result_stall
);

	bk_state_t     state_q, state_nx;
	logic [7:0]    mem [LINE_MAX];
	logic [7:0]    rd_data_q;
	logic [7:0]    ch_q;
	logic [5:0]    col_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] stop_q;
	logic [PW-1:0] pos_nx;
	logic [TW-1:0] tabs_q;
	logic [3:0]    sp_q;
	logic [TW-1:0] tabs_e;
	logic [3:0]    sp_e;
	logic          boundary;
	logic          is_sp;
	logic          emit_ok;
	logic          emit;
	logic          mem_we;
	result_t       emit_val;
	result_t       res_q;
	logic          res_valid_q;

	assign emit_ok  = !res_valid_q || !result_stall;
	assign pos_nx   = pos_q + PW'(1);
	assign is_sp    = (rd_data_q == CH_SP);
	assign boundary = (pos_q[2:0] == 3'd0) && (sp_q != 4'd0);
	assign tabs_e   = tabs_q + TW'(boundary);
	assign sp_e     = boundary ? 4'd0 : sp_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_WRITE:   state_nx = BK_WRITE;
						CMD_RELEASE: state_nx = (cmd_stop == '0) ? BK_TRIG : BK_FETCH;
						default:     state_nx = BK_STATUS;
					endcase
				end
			end
			BK_WRITE: begin
				if (pos_nx == stop_q) state_nx = BK_STATUS;
			end
			BK_FETCH: state_nx = BK_EXAM;
			BK_EXAM: begin
				if (!is_sp)                 state_nx = BK_PEND;
				else if (pos_nx == stop_q)  state_nx = BK_TRIG;
				else                        state_nx = BK_FETCH;
			end
			BK_PEND: begin
				if (emit_ok && tabs_q == '0 && sp_q == 4'd0) begin
					state_nx = (pos_nx == stop_q) ? BK_TRIG : BK_FETCH;
				end
			end
			BK_TRIG: begin
				if (emit_ok) state_nx = BK_IDLE;
			end
			BK_STATUS: begin
				if (emit_ok) state_nx = BK_IDLE;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_pop  = 1'b0;
		mem_we   = 1'b0;
		emit     = 1'b0;
		emit_val = '{out_char: CH_NUL, char_valid: 1'b0, last: 1'b0, column: 6'd0};
		case (state_q)
			BK_IDLE:  cmd_pop = cmd_valid;
			BK_WRITE: mem_we  = 1'b1;
			BK_PEND: begin
				emit = emit_ok;
				emit_val.char_valid = 1'b1;
				if (tabs_q != '0)      emit_val.out_char = CH_TAB;
				else if (sp_q != 4'd0) emit_val.out_char = CH_SP;
				else                   emit_val.out_char = rd_data_q;
			end
			BK_TRIG: begin
				emit = emit_ok;
				emit_val.out_char   = ch_q;
				emit_val.char_valid = 1'b1;
				emit_val.last       = 1'b1;
			end
			BK_STATUS: begin
				emit = emit_ok;
				emit_val.last   = 1'b1;
				emit_val.column = col_q;
			end
			default: ;
		endcase
	end

	// Line store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q[AW-1:0]] <= ch_q;
		end
		rd_data_q <= mem[pos_q[AW-1:0]];
	end

	// Command fields and walk counters
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					ch_q   <= cmd.ch;
					col_q  <= cmd.column;
					pos_q  <= cmd_start;
					stop_q <= cmd_stop;
					tabs_q <= '0;
					sp_q   <= 4'd0;
				end
			end
			BK_WRITE: pos_q <= pos_nx;
			BK_EXAM: begin
				tabs_q <= tabs_e;
				if (is_sp) begin
					sp_q  <= sp_e + 4'd1;
					pos_q <= pos_nx;
				end else begin
					sp_q <= sp_e;
				end
			end
			BK_PEND: begin
				if (emit_ok) begin
					if (tabs_q != '0)      tabs_q <= tabs_q - TW'(1);
					else if (sp_q != 4'd0) sp_q   <= sp_q - 4'd1;
					else                   pos_q  <= pos_nx;
				end
			end
			default: ;
		endcase
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_val;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

`ifndef SYNTHESIS
	// The walk never runs past the released length
	a_pend_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_PEND || state_q == BK_EXAM) |-> (pos_q < stop_q))
		else $error("walk position beyond line length");

	// Writes stay inside the command's span
	a_write_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WRITE) |-> (pos_q < stop_q && pos_q < PW'(LINE_MAX)))
		else $error("store write outside span");

	// A pending space run never exceeds one tab stop
	a_space_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_PEND) |-> (sp_q < 4'd8))
		else $error("space run too long at emission");

	// Every character result of a release, its end included, reports an empty line
	a_release_col: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.char_valid) |-> (res_q.column == 6'd0))
		else $error("release result with nonzero column");
`endif

endmodule

`default_nettype wire

// ===== verif/lbtc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the line buffer tab compressor: watches the item and result
// channels, predicts each item's results and compares them in order.
// Depends on lbtc_pkg.
module lbtc_checker import lbtc_pkg::*; #(
	parameter int LINE_MAX = LBTC_LINE_MAX
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	input  logic    item_stall,
	input  result_t result,
	input  logic    result_valid,
	input  logic    result_stall,
	output int      fail_count,
	output int      pending,
	output int      item_count,
	output int      result_count,
	output int      release_count,
	output int      full_release_count
);

	// Predicted line store and fill position
	logic [7:0] line_chars [LINE_MAX];
	int         fill_pos;
	result_t    due_results [$];

	function automatic result_t char_out(logic [7:0] ch);
		result_t r;
		r = '0;
		r.out_char = ch;
		r.char_valid = 1'b1;
		return r;
	endfunction

	task automatic push_status();
		result_t r;
		r = '0;
		r.last = 1'b1;
		r.column = fill_pos[5:0];
		due_results.push_back(r);
	endtask

	// Walk the stored line: space runs crossing a tab stop become tabs,
	// trailing spaces vanish, the trigger byte closes the line.
	task automatic drain_line(input logic [7:0] trig);
		int      tabs;
		int      spaces;
		result_t r;
		tabs = 0;
		spaces = 0;
		for (int p = 0; p < fill_pos; p++) begin
			if (p % 8 == 0 && spaces != 0) begin
				tabs++;
				spaces = 0;
			end
			if (line_chars[p] == CH_SP) begin
				spaces++;
			end else begin
				while (tabs > 0) begin
					due_results.push_back(char_out(CH_TAB));
					tabs--;
				end
				while (spaces > 0) begin
					due_results.push_back(char_out(CH_SP));
					spaces--;
				end
				due_results.push_back(char_out(line_chars[p]));
			end
		end
		r = char_out(trig);
		r.last = 1'b1;
		due_results.push_back(r);
		fill_pos = 0;
		release_count++;
	endtask

	task automatic entab_item(input item_t it);
		if (it.suppress) begin
			push_status();
		end else if (it.op == OP_FLUSH) begin
			if (fill_pos != 0)
				drain_line(CH_NL);
			else
				push_status();
		end else if (it.char_code == CH_NL || fill_pos >= LINE_MAX) begin
			if (it.char_code != CH_NL)
				full_release_count++;
			drain_line(it.char_code);
		end else begin
			if (it.char_code == CH_TAB) begin
				// expand to the next tab stop, clipped at the end of the store
				line_chars[fill_pos] = CH_SP;
				fill_pos++;
				while (fill_pos % 8 != 0 && fill_pos < LINE_MAX) begin
					line_chars[fill_pos] = CH_SP;
					fill_pos++;
				end
			end else if (it.char_code != CH_NUL) begin
				line_chars[fill_pos] = it.char_code;
				fill_pos++;
			end
			push_status();
		end
	endtask

	// Predict on item transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			fill_pos = 0;
			due_results.delete();
			fail_count = 0;
			pending = 0;
			item_count = 0;
			result_count = 0;
			release_count = 0;
			full_release_count = 0;
		end else begin
			if (item_valid && !item_stall) begin
				entab_item(item);
				item_count++;
			end
			if (result_valid && !result_stall) begin
				result_count++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 30)
						$display("%0t: unexpected result: char %02h valid %0b last %0b col %0d",
							$time, result.out_char, result.char_valid, result.last,
							result.column);
				end else begin
					want = due_results.pop_front();
					if (result !== want) begin
						fail_count++;
						if (fail_count <= 30)
							$display("%0t: result mismatch: expected char %02h valid %0b ",
								$time, want.out_char, want.char_valid,
								"last %0b col %0d, got char %02h valid %0b last %0b col %0d",
								want.last, want.column, result.out_char, result.char_valid,
								result.last, result.column);
					end
				end
			end
			pending = due_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the line buffer tab compressor: clock, reset, item
// stimulus, result back-pressure and verdict. Depends on lbtc_pkg,
// lbtc_checker and the block itself.
module tb;
	import lbtc_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	item_t   item = '0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall = 1'b1;

	// no idling on either side while set
	logic    steady = 1'b0;
	int      sent = 0;

	int fail_count, pending, item_count, result_count, release_count, full_release_count;

	line_buffer_tab_compressor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	lbtc_checker #(.LINE_MAX(LBTC_LINE_MAX)) chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.item              (item),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.result            (result),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.fail_count        (fail_count),
		.pending           (pending),
		.item_count        (item_count),
		.result_count      (result_count),
		.release_count     (release_count),
		.full_release_count(full_release_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Present one item after a random gap and hold it until the transfer
	task automatic send(input logic op, input logic [7:0] ch, input logic sup);
		int    gap;
		item_t it;
		gap = steady ? 0 : $urandom_range(0, 13);
		it.op = op;
		it.char_code = ch;
		it.suppress = sup;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic put(input logic [7:0] ch);
		send(OP_PUT, ch, 1'b0);
	endtask

	// Text-like mix: heavy on spaces so tab stops get crossed often
	function automatic logic [7:0] line_char();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return CH_SP;
		else if (k < 50)
			return CH_TAB;
		else if (k < 53)
			return CH_NUL;
		else if (k < 88)
			return 8'($urandom_range(33, 126));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// Result side: random stall before each result
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	initial begin
		int len;
		int k;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty flush, suppression, newline on empty store
		send(OP_FLUSH, 8'hFF, 1'b0);
		send(OP_PUT, CH_NL, 1'b1);
		put(CH_NL);
		// ignored zero, extreme bytes, tab expansion, trailing space on flush
		put(8'h41);
		put(CH_NUL);
		put(8'hFF);
		send(OP_FLUSH, 8'h00, 1'b1);
		put(CH_TAB);
		put(8'h80);
		put(CH_SP);
		put(CH_SP);
		put(CH_TAB);
		put(8'h01);
		put(CH_SP);
		send(OP_FLUSH, 8'hFF, 1'b0);
		send(OP_FLUSH, 8'h00, 1'b0);
		// full store released by a raw tab, then by a raw zero
		repeat (7) put(CH_TAB);
		put(CH_TAB);
		repeat (7) put(CH_TAB);
		put(CH_NUL);

		// Random lines, mostly short, some long enough to fill the store
		while (sent < 410) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(50, 64);
			else
				len = $urandom_range(0, 24);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 24) == 0)
					send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
				else
					put(line_char());
			end
			k = $urandom_range(0, 9);
			if (k < 6)
				put(CH_NL);
			else if (k < 9)
				send(OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0);
		end
		item_valid <= 1'b0;
		steady = 1'b0;

		// Drain once the checker has seen the last transfer, then catch stray results
		do @(negedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		$display("tb: %0d items, %0d results checked, %0d failures", item_count,
			result_count, fail_count);
		$display("tb: %0d lines released, %0d of them by a full store", release_count,
			full_release_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule
